// ===== rtl/aho_pkg.sv =====
// ----------------------------------------------------------------------------
// aho_pkg
// Shared codes and helpers for the Aho-Corasick match counter.
// ----------------------------------------------------------------------------
package aho_pkg;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_BUILD  = 3'd1,
		ACT_BEGIN  = 3'd2,
		ACT_TEXT   = 3'd3,
		ACT_PROP   = 3'd4,
		ACT_QUERY  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_SYMBOL = 2'd2,
		ST_PHASE  = 2'd3
	} status_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== rtl/aho_corasick_match_counter.sv =====
// Insert runs through S_INS, query through S_QRY and a text symbol through S_TXT1 and S_TXT2
// before S_RESP registers the result; an action that fails its check goes straight to S_RESP.
// The block takes the next item in the cycle after its result is registered, so it works on one item at a time.
// Build walks every trie node through each symbol of the alphabet, held back by the single goto read port;
// propagate visits each node in turn; begin text sweeps all MAX_NODES entries of the count memory.
// After reset a clearing sweep over the whole goto memory and the count memory runs first.
// ----------------------------------------------------------------------------
// aho_corasick_match_counter
// Multi-pattern matcher with the trie, links, queue and counts held in
// synchronous memories driven by a sequencer.
// ----------------------------------------------------------------------------
module aho_corasick_match_counter #(
	parameter int MAX_NODES     = 256,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  symbol,
	input  logic        pattern_start,
	input  logic [7:0]  node_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  node,
	output logic [31:0] count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int SW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int GA = NW + SW;
	localparam int GD = 1 << GA;
	localparam logic [NW-1:0] ROOT = NW'(1);
	localparam logic [NW:0] MAXN = (NW+1)'(MAX_NODES);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_INS, S_TXT1, S_TXT2, S_QRY, S_TCLR,
		S_BINIT, S_BPOP, S_BX, S_BFX, S_BRC, S_BRV, S_BW,
		S_PPOP, S_PX, S_PF, S_PW, S_RESP
	} state_t;

	state_t state_q;

	logic [NW-1:0] goto_mem [GD];
	logic [NW-1:0] fail_mem [MAX_NODES];
	logic [NW-1:0] order_mem [MAX_NODES];
	logic [31:0]   visit_mem [MAX_NODES];

	logic          g_we, f_we, b_we, v_we;
	logic [GA-1:0] g_wa, g_ra;
	logic [NW-1:0] g_wd, g_rd, f_wa, f_wd, f_ra, f_rd, b_wa, b_wd, b_ra, b_rd, v_wa, v_ra;
	logic [31:0]   v_wd, v_rd;

	logic [7:0]    base_q;
	logic [NW-1:0] cur_q, p_q, x_q, fx_q, c_q, f_q, nd_q;
	logic [NW:0]   used_q, olen_q, head_q, tail_q, ptr_q;
	logic [SW-1:0] idx_q, i_q;
	logic [GA:0]   clr_q;
	logic          built_q, qin_q;
	logic [1:0]    st_q;
	logic [31:0]   cnt_q, v_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [7:0]    out_node_q;
	logic [31:0]   out_count_q;

	logic          accept;
	logic [7:0]    sym8;
	logic          sym_ok;
	logic [SW-1:0] sym_idx;
	logic [NW-1:0] ins_p;
	logic [NW:0]   used_inc;
	logic          q_ok;
	logic [NW-1:0] q_addr;

	always_ff @(posedge clk) begin
		if (g_we) goto_mem[g_wa] <= g_wd;
		g_rd <= goto_mem[g_ra];
	end

	always_ff @(posedge clk) begin
		if (f_we) fail_mem[f_wa] <= f_wd;
		f_rd <= fail_mem[f_ra];
	end

	always_ff @(posedge clk) begin
		if (b_we) order_mem[b_wa] <= b_wd;
		b_rd <= order_mem[b_ra];
	end

	always_ff @(posedge clk) begin
		if (v_we) visit_mem[v_wa] <= v_wd;
		v_rd <= visit_mem[v_ra];
	end

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign sym8      = symbol - base_q;
	assign sym_ok    = {1'b0, sym8} < 9'(ALPHABET_SIZE);
	assign sym_idx   = sym8[SW-1:0];
	assign ins_p     = pattern_start ? ROOT : cur_q;
	assign used_inc  = used_q + 1'b1;
	assign q_ok      = 17'(node_index) < 17'(MAX_NODES);
	assign q_addr    = NW'(node_index);

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign node      = out_node_q;
	assign count     = out_count_q;

	always_comb begin
		g_we = 1'b0; g_wa = {p_q, idx_q}; g_wd = NW'(used_inc); g_ra = {cur_q, sym_idx};
		f_we = 1'b0; f_wa = c_q; f_wd = g_rd; f_ra = b_rd;
		b_we = 1'b0; b_wa = tail_q[NW-1:0]; b_wd = c_q; b_ra = head_q[NW-1:0];
		v_we = 1'b0; v_wa = x_q; v_wd = aho_pkg::sat_add(v_rd, 32'd1); v_ra = q_addr;
		unique case (state_q)
			S_CLR: begin
				g_we = 1'b1;
				g_wa = clr_q[GA-1:0];
				g_wd = (clr_q[GA-1:SW] == '0) ? ROOT : '0;
				v_we = (clr_q < (GA+1)'(MAX_NODES));
				v_wa = clr_q[NW-1:0];
				v_wd = '0;
			end
			S_IDLE: begin
				if (action == aho_pkg::ACT_INSERT) g_ra = {ins_p, sym_idx};
			end
			S_INS: begin
				g_we = (g_rd == '0) && (used_inc < MAXN);
			end
			S_TXT1: v_ra = g_rd;
			S_TXT2: v_we = 1'b1;
			S_TCLR: begin
				v_we = 1'b1;
				v_wa = clr_q[NW-1:0];
				v_wd = '0;
			end
			S_BINIT: begin
				b_we = 1'b1;
				b_wa = '0;
				b_wd = ROOT;
			end
			S_BRC: g_ra = {x_q, i_q};
			S_BRV: g_ra = {fx_q, i_q};
			S_BW: begin
				if (c_q == '0) begin
					g_we = 1'b1;
					g_wa = {x_q, i_q};
					g_wd = g_rd;
				end else if (tail_q < MAXN) begin
					f_we = 1'b1;
					b_we = 1'b1;
				end
			end
			S_PPOP: b_ra = NW'(ptr_q - 1'b1);
			S_PX: v_ra = b_rd;
			S_PF: v_ra = f_rd;
			S_PW: begin
				v_we = 1'b1;
				v_wa = f_q;
				v_wd = aho_pkg::sat_add(v_rd, v_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			base_q       <= 8'd97;
			cur_q        <= ROOT;
			used_q       <= (NW+1)'(1);
			olen_q       <= '0;
			built_q      <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			ptr_q        <= '0;
			i_q          <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= aho_pkg::ST_OK;
			out_node_q   <= '0;
			out_count_q  <= '0;
			st_q         <= aho_pkg::ST_OK;
			nd_q         <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_valid) base_q <= cfg_data;
			if (out_valid_q && !out_stall && state_q != S_RESP) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (GA+1)'(GD - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						st_q  <= aho_pkg::ST_OK;
						nd_q  <= '0;
						cnt_q <= '0;
						state_q <= S_RESP;
						case (action)
							aho_pkg::ACT_INSERT: begin
								if (built_q) st_q <= aho_pkg::ST_PHASE;
								else if (!sym_ok) st_q <= aho_pkg::ST_SYMBOL;
								else begin
									p_q     <= ins_p;
									idx_q   <= sym_idx;
									state_q <= S_INS;
								end
							end
							aho_pkg::ACT_BUILD: begin
								if (built_q) st_q <= aho_pkg::ST_PHASE;
								else state_q <= S_BINIT;
							end
							aho_pkg::ACT_BEGIN: begin
								if (!built_q) st_q <= aho_pkg::ST_PHASE;
								else begin
									clr_q   <= '0;
									cur_q   <= ROOT;
									state_q <= S_TCLR;
								end
							end
							aho_pkg::ACT_TEXT: begin
								if (!built_q) st_q <= aho_pkg::ST_PHASE;
								else if (!sym_ok) st_q <= aho_pkg::ST_SYMBOL;
								else state_q <= S_TXT1;
							end
							aho_pkg::ACT_PROP: begin
								if (!built_q) st_q <= aho_pkg::ST_PHASE;
								else begin
									ptr_q   <= olen_q;
									state_q <= S_PPOP;
								end
							end
							aho_pkg::ACT_QUERY: begin
								qin_q   <= q_ok;
								state_q <= S_QRY;
							end
							default: st_q <= aho_pkg::ST_PHASE;
						endcase
					end
				end
				S_INS: begin
					state_q <= S_RESP;
					if (g_rd != '0) begin
						cur_q <= g_rd;
						nd_q  <= g_rd;
					end else if (used_inc < MAXN) begin
						used_q <= used_inc;
						cur_q  <= NW'(used_inc);
						nd_q   <= NW'(used_inc);
					end else begin
						st_q <= aho_pkg::ST_FULL;
					end
				end
				S_TXT1: begin
					x_q     <= g_rd;
					cur_q   <= g_rd;
					state_q <= S_TXT2;
				end
				S_TXT2: begin
					nd_q    <= x_q;
					state_q <= S_RESP;
				end
				S_QRY: begin
					cnt_q   <= qin_q ? v_rd : 32'd0;
					state_q <= S_RESP;
				end
				S_TCLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (GA+1)'(MAX_NODES - 1)) state_q <= S_RESP;
				end
				S_BINIT: begin
					head_q  <= '0;
					tail_q  <= (NW+1)'(1);
					state_q <= S_BPOP;
				end
				S_BPOP: begin
					if (head_q == tail_q) begin
						olen_q  <= tail_q;
						built_q <= 1'b1;
						cur_q   <= ROOT;
						state_q <= S_RESP;
					end else begin
						state_q <= S_BX;
					end
				end
				S_BX: begin
					x_q     <= b_rd;
					state_q <= S_BFX;
				end
				S_BFX: begin
					fx_q    <= (x_q == ROOT) ? '0 : f_rd;
					i_q     <= '0;
					state_q <= S_BRC;
				end
				S_BRC: state_q <= S_BRV;
				S_BRV: begin
					c_q     <= g_rd;
					state_q <= S_BW;
				end
				S_BW: begin
					if (c_q != '0 && tail_q < MAXN) tail_q <= tail_q + 1'b1;
					if (i_q == SW'(ALPHABET_SIZE - 1)) begin
						head_q  <= head_q + 1'b1;
						state_q <= S_BPOP;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_BRC;
					end
				end
				S_PPOP: begin
					if (ptr_q == '0) state_q <= S_RESP;
					else begin
						ptr_q   <= ptr_q - 1'b1;
						state_q <= S_PX;
					end
				end
				S_PX: begin
					state_q <= (b_rd == ROOT) ? S_PPOP : S_PF;
				end
				S_PF: begin
					f_q     <= f_rd;
					v_q     <= v_rd;
					state_q <= S_PW;
				end
				S_PW: state_q <= S_PPOP;
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= st_q;
						out_node_q   <= 8'(nd_q);
						out_count_q  <= cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/aho_checker.sv =====
// ----------------------------------------------------------------------------
// aho_checker
// Port-level checks for the Aho-Corasick match counter.
// ----------------------------------------------------------------------------
module aho_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  node,
	input logic [31:0] count
);

	// A result waiting under stall stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A failed action reports neither a node nor a count.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != aho_pkg::ST_OK |-> node == 8'd0 && count == 32'd0)
		else $error("error result carries data");

	// An input transfer always occupies the block for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	// Only a query returns a count, and a query never reports a node.
	a_cnt_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count != 32'd0 |-> node == 8'd0)
		else $error("count and node both set");

endmodule

bind aho_corasick_match_counter aho_checker u_aho_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.node      (node),
	.count     (count)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Aho-Corasick match counter. Patterns fill the
// trie up to a full table, links are built once, then several text passes
// under different symbol bases are counted, propagated and read back. Every
// result is checked against a behavioral copy of the automaton, with random
// gaps on the input side and random stalls on the output side, but for one quiet pass.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NODES = 256;
	localparam int ALPHA = 26;
	localparam int ROOT  = 1;

	typedef struct {
		aho_pkg::status_t st;
		logic [7:0]       nd;
		logic [31:0]      cnt;
	} match_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = 3'd0;
	logic [7:0]  symbol = 8'd0;
	logic        pattern_start = 1'b0;
	logic [7:0]  node_index = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [7:0]  node;
	logic [31:0] count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;

	match_result_t pending_results[$];
	int            errors = 0;
	int            items_sent = 0;
	int            results_seen = 0;
	bit            quiet = 1'b0;

	int          trie[NODES * ALPHA];
	int          fail_of[NODES];
	int          bfs[NODES];
	int          bfs_len;
	logic [31:0] hits[NODES];
	int          used;
	int          cur;
	bit          built;
	logic [7:0]  base;

	aho_corasick_match_counter #(.MAX_NODES(NODES), .ALPHABET_SIZE(ALPHA)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .symbol(symbol), .pattern_start(pattern_start),
		.node_index(node_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .node(node), .count(count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic void automaton_reset();
		for (int i = 0; i < NODES * ALPHA; i++) trie[i] = (i < ALPHA) ? ROOT : 0;
		for (int i = 0; i < NODES; i++) begin
			fail_of[i] = 0;
			bfs[i] = 0;
			hits[i] = 32'd0;
		end
		bfs_len = 0;
		used = 1;
		cur = ROOT;
		built = 1'b0;
		base = 8'd97;
	endfunction

	function automatic void build_automaton();
		int head, tail, x, fx, c, via;
		head = 0;
		tail = 0;
		bfs[tail++] = ROOT;
		while (head < tail) begin
			x = bfs[head++];
			fx = fail_of[x];
			for (int i = 0; i < ALPHA; i++) begin
				c = trie[x * ALPHA + i];
				via = trie[fx * ALPHA + i];
				if (c == 0) begin
					trie[x * ALPHA + i] = via;
				end else if (tail < NODES) begin
					fail_of[c % NODES] = via;
					bfs[tail++] = c;
				end
			end
		end
		bfs_len = tail;
	endfunction

	function automatic match_result_t automaton_step(input logic [2:0] a, input logic [7:0] s,
			input logic p, input logic [7:0] q);
		match_result_t r;
		logic [7:0] d;
		int par, nx, x;
		r.st = aho_pkg::ST_OK;
		r.nd = 8'd0;
		r.cnt = 32'd0;
		d = s - base;
		case (a)
			aho_pkg::ACT_INSERT: begin
				par = p ? ROOT : cur;
				if (built) r.st = aho_pkg::ST_PHASE;
				else if (d >= ALPHA) r.st = aho_pkg::ST_SYMBOL;
				else begin
					nx = trie[par * ALPHA + d];
					if (nx == 0 && used + 1 >= NODES) r.st = aho_pkg::ST_FULL;
					else begin
						if (nx == 0) begin
							used++;
							nx = used;
							trie[par * ALPHA + d] = nx;
						end
						cur = nx;
						r.nd = nx[7:0];
					end
				end
			end
			aho_pkg::ACT_BUILD: begin
				if (built) r.st = aho_pkg::ST_PHASE;
				else begin
					build_automaton();
					built = 1'b1;
					cur = ROOT;
				end
			end
			aho_pkg::ACT_BEGIN: begin
				if (!built) r.st = aho_pkg::ST_PHASE;
				else begin
					for (int i = 0; i < NODES; i++) hits[i] = 32'd0;
					cur = ROOT;
				end
			end
			aho_pkg::ACT_TEXT: begin
				if (!built) r.st = aho_pkg::ST_PHASE;
				else if (d >= ALPHA) r.st = aho_pkg::ST_SYMBOL;
				else begin
					cur = trie[cur * ALPHA + d];
					hits[cur % NODES] = sat32(hits[cur % NODES], 32'd1);
					r.nd = cur[7:0];
				end
			end
			aho_pkg::ACT_PROP: begin
				if (!built) r.st = aho_pkg::ST_PHASE;
				else begin
					for (int i = bfs_len; i > 0; i--) begin
						x = bfs[i - 1] % NODES;
						if (x != ROOT)
							hits[fail_of[x] % NODES] = sat32(hits[fail_of[x] % NODES], hits[x]);
					end
				end
			end
			aho_pkg::ACT_QUERY: r.cnt = hits[q];
			default: r.st = aho_pkg::ST_PHASE;
		endcase
		return r;
	endfunction

	always @(negedge clk) begin
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 30);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d node %0d count %0d", status, node, count);
				errors++;
			end else begin
				match_result_t e;
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					errors++;
				end
				if (node !== e.nd) begin
					$error("node: expected %0d, actual %0d", e.nd, node);
					errors++;
				end
				if (count !== e.cnt) begin
					$error("count: expected %0d, actual %0d", e.cnt, count);
					errors++;
				end
			end
		end
	end

	task automatic send_item(input logic [2:0] a, input logic [7:0] s, input logic p,
			input logic [7:0] q);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 30) begin
			gap = $urandom_range(4, 1);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		symbol <= s;
		pattern_start <= p;
		node_index <= q;
		do @(posedge clk); while (in_stall);
		pending_results.insert(pending_results.size(), automaton_step(a, s, p, q));
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_base(input logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		base = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_before_build();
		send_item(aho_pkg::ACT_QUERY, 8'd0, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_QUERY, 8'd0, 1'b0, 8'd255);
		send_item(aho_pkg::ACT_BEGIN, 8'd0, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_TEXT, 8'd97, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_PROP, 8'd0, 1'b0, 8'd0);
		send_item(3'd6, 8'hFF, 1'b1, 8'hFF);
		send_item(3'd7, 8'h00, 1'b0, 8'h00);
		send_item(aho_pkg::ACT_INSERT, 8'd65, 1'b1, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd97, 1'b1, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd122, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd123, 1'b0, 8'd0);
		drain();
		write_base(8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd0, 1'b1, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd25, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd26, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd255, 1'b0, 8'd0);
		drain();
		write_base(8'd255);
		send_item(aho_pkg::ACT_INSERT, 8'd255, 1'b1, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd24, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd25, 1'b0, 8'd0);
		drain();
		write_base(8'd97);
	endtask

	task automatic test_patterns();
		int len, extra;
		extra = 0;
		while (extra < 10) begin
			if ($urandom_range(99) < 10) begin
				send_item(aho_pkg::ACT_INSERT, 8'($urandom), 1'($urandom), 8'($urandom));
			end else begin
				len = $urandom_range(7, 1);
				for (int i = 0; i < len; i++)
					send_item(aho_pkg::ACT_INSERT, base + 8'($urandom_range(ALPHA - 1)),
						i == 0, 8'($urandom));
			end
			if (used >= NODES - 1) extra++;
		end
		drain();
	endtask

	task automatic test_build();
		send_item(aho_pkg::ACT_BUILD, 8'($urandom), 1'b0, 8'd0);
		send_item(aho_pkg::ACT_BUILD, 8'd0, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_INSERT, 8'd97, 1'b1, 8'd0);
		send_item(aho_pkg::ACT_QUERY, 8'd0, 1'b0, 8'd1);
		drain();
	endtask

	task automatic text_pass(input logic [7:0] b, input int len);
		write_base(b);
		send_item(aho_pkg::ACT_BEGIN, 8'($urandom), 1'($urandom), 8'($urandom));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 10)
				send_item(aho_pkg::ACT_TEXT, 8'($urandom), 1'($urandom), 8'($urandom));
			else
				send_item(aho_pkg::ACT_TEXT, base + 8'($urandom_range(ALPHA - 1)),
					1'($urandom), 8'($urandom));
		end
		send_item(aho_pkg::ACT_PROP, 8'd0, 1'b0, 8'd0);
		if ($urandom_range(1)) send_item(aho_pkg::ACT_PROP, 8'd0, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_QUERY, 8'd0, 1'b0, 8'd0);
		send_item(aho_pkg::ACT_QUERY, 8'd0, 1'b0, 8'd1);
		for (int i = 0; i < 20; i++)
			send_item(aho_pkg::ACT_QUERY, 8'($urandom), 1'b0, 8'($urandom));
		drain();
	endtask

	task automatic test_text();
		text_pass(8'd97, 80);
		text_pass(8'd0, 60);
		text_pass(8'd255, 60);
		quiet = 1'b1;
		text_pass(8'd97, 100);
		quiet = 1'b0;
		for (int k = 0; k < 3; k++) text_pass(8'($urandom), 40);
		text_pass(8'd97, 80);
		for (int i = 0; i < NODES; i++) send_item(aho_pkg::ACT_QUERY, 8'd0, 1'b0, 8'(i));
		drain();
	endtask

	initial begin
		automaton_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_base(8'd97);
		test_before_build();
		test_patterns();
		test_build();
		test_text();
		$display("Covered %0d items and %0d results: trie fill to full table, one build,",
			items_sent, results_seen);
		$display("text passes under several symbol bases, repeated propagation and reads.");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/aho_pkg.sv
rtl/aho_corasick_match_counter.sv
rtl/aho_checker.sv
tb/sv/tb_top.sv
